/* rtl/ax25fb_pkg.sv */
// ax25fb_pkg: operation codes, crc constants and the byte-wise crc-16/x.25 update
// used by the frame builder, its channel interfaces and its checker
// no dependencies
`default_nettype none

package ax25fb_pkg;

	localparam int unsigned OP_W   = 2;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CRC_W  = 16;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CRC_W-1:0]  crc_t;

	localparam op_t OP_ADDR_CHAR = 2'd0;
	localparam op_t OP_ADDR_SSID = 2'd1;
	localparam op_t OP_PLAIN     = 2'd2;

	localparam crc_t CRC_POLY_REFL = 16'h8408;
	localparam crc_t CRC_START     = 16'hFFFF;

	// reflected crc, one byte, eight xor/shift steps on a 16-bit word
	function automatic crc_t crc_add_byte(input crc_t crc, input byte_t b);
		crc_t c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/ax25fb_if.sv */
// ax25fb_in_if / ax25fb_out_if: valid/ready channels for field beats and frame beats
// depends on ax25fb_pkg
`default_nettype none

interface ax25fb_in_if;
	import ax25fb_pkg::*;

	logic  valid;
	logic  ready;
	op_t   operation;
	byte_t data_byte;
	logic  address_end;
	logic  end_of_frame;

	modport source (output valid, output operation, output data_byte,
		output address_end, output end_of_frame, input ready);
	modport sink (input valid, input operation, input data_byte,
		input address_end, input end_of_frame, output ready);
endinterface

interface ax25fb_out_if;
	import ax25fb_pkg::*;

	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  frame_start;
	logic  frame_last;

	modport source (output valid, output out_byte, output frame_start,
		output frame_last, input ready);
	modport sink (input valid, input out_byte, input frame_start,
		input frame_last, output ready);
endinterface

`default_nettype wire

/* rtl/ax25_frame_builder_fcs_top.sv */
// ax25_frame_builder_fcs_top: ax.25 frame byte builder with crc-16/x.25 fcs append
// depends on ax25fb_pkg and the channel interfaces in ax25fb_if.sv
//
//  channel    dir  beat contents
//  ---------  ---  ----------------------------------------------------
//  frame_in   in   operation, data_byte, address_end, end_of_frame
//  frame_out  out  out_byte, frame_start, frame_last
//
// one field beat per cycle while output is free; a beat passes an input register,
// then the address shift and the byte-wide crc update into the output register;
// an end_of_frame beat is followed by two fcs beats and holds the output register
// until the fcs high byte leaves; the next frame byte waits in the input register
// reset clears both stages, restarts the crc at ffff and marks no frame begun
// a stalled output keeps one further field beat in the input register
`default_nettype none

module ax25_frame_builder_fcs_top (
	input  wire          clk,
	input  wire          arst_n,
	ax25fb_in_if.sink    frame_in,
	ax25fb_out_if.source frame_out
);
	import ax25fb_pkg::*;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_FCS_LO,
		TAIL_FCS_HI
	} tail_t;

	// input register
	logic  valid_s1;
	op_t   op_s1;
	byte_t data_s1;
	logic  addr_end_s1;
	logic  eof_s1;

	// frame state
	crc_t  crc_q;
	logic  inside_q;

	// output register
	tail_t tail_q;
	logic  out_valid_q;
	byte_t out_byte_q;
	logic  out_start_q;
	logic  out_last_q;
	crc_t  fcs_q;

	byte_t byte_c;
	crc_t  crc_next;
	logic  out_free;
	logic  load;

	always_comb begin
		case (op_s1)
			OP_ADDR_CHAR: byte_c = {data_s1[BYTE_W-2:0], 1'b0};
			OP_ADDR_SSID: byte_c = {data_s1[BYTE_W-2:0], addr_end_s1};
			default:      byte_c = data_s1;
		endcase
	end

	assign crc_next = crc_add_byte(crc_q, byte_c);

	// output register frees when its last beat of the item leaves
	assign out_free = !out_valid_q || (frame_out.ready && tail_q == TAIL_NONE);
	assign load     = valid_s1 && out_free;

	assign frame_in.ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			op_s1       <= frame_in.operation;
			data_s1     <= frame_in.data_byte;
			addr_end_s1 <= frame_in.address_end;
			eof_s1      <= frame_in.end_of_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q      <= TAIL_NONE;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_start_q <= 1'b0;
			out_last_q  <= 1'b0;
			fcs_q       <= '0;
			crc_q       <= CRC_START;
			inside_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			out_byte_q  <= byte_c;
			out_start_q <= !inside_q;
			out_last_q  <= 1'b0;
			fcs_q       <= ~crc_next;
			tail_q      <= eof_s1 ? TAIL_FCS_LO : TAIL_NONE;
			crc_q       <= eof_s1 ? CRC_START : crc_next;
			inside_q    <= !eof_s1;
		end else if (out_valid_q && frame_out.ready) begin
			case (tail_q)
				TAIL_FCS_LO: begin
					out_byte_q  <= fcs_q[BYTE_W-1:0];
					out_start_q <= 1'b0;
					out_last_q  <= 1'b0;
					tail_q      <= TAIL_FCS_HI;
				end
				TAIL_FCS_HI: begin
					out_byte_q  <= fcs_q[CRC_W-1:BYTE_W];
					out_start_q <= 1'b0;
					out_last_q  <= 1'b1;
					tail_q      <= TAIL_NONE;
				end
				default: begin
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign frame_out.valid       = out_valid_q;
	assign frame_out.out_byte    = out_byte_q;
	assign frame_out.frame_start = out_start_q;
	assign frame_out.frame_last  = out_last_q;

endmodule

`default_nettype wire

/* rtl/ax25fb_checker.sv */
// ax25fb_checker: port-level checks on the frame builder, bound to its top level
// depends on ax25fb_pkg and ax25_frame_builder_fcs_top
`default_nettype none

module ax25fb_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_ready,
	input wire               in_eof,
	input wire               out_valid,
	input wire               out_ready,
	input ax25fb_pkg::byte_t out_byte,
	input wire               out_start,
	input wire               out_last
);
	import ax25fb_pkg::*;

	logic       in_beat;
	logic       out_beat;
	logic [1:0] open_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// frames whose end has been taken in but whose fcs high byte is not yet out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			case ({in_beat && in_eof, out_beat && out_last})
				2'b10:   open_q <= open_q + 2'd1;
				2'b01:   open_q <= open_q - 2'd1;
				default: open_q <= open_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(out_start) && $stable(out_last))
		else $error("frame beat changed while stalled");

	a_fcs_not_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> !out_start)
		else $error("fcs high byte flagged as frame start");

	a_last_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && out_last |-> open_q != 2'd0)
		else $error("frame end without a frame end taken in");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q != 2'd3)
		else $error("more frame ends in flight than the two stages hold");

endmodule

bind ax25_frame_builder_fcs_top ax25fb_checker u_ax25fb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame_in.valid),
	.in_ready  (frame_in.ready),
	.in_eof    (frame_in.end_of_frame),
	.out_valid (frame_out.valid),
	.out_ready (frame_out.ready),
	.out_byte  (frame_out.out_byte),
	.out_start (frame_out.frame_start),
	.out_last  (frame_out.frame_last)
);

`default_nettype wire
